### hdl/bae_pkg.sv
// Shared types, constants and functions for the bech32 address encoder.
// No dependencies; used by every module under hdl.
package bae_pkg;

	localparam int unsigned QDEPTH_DEF = 4;

	localparam logic [29:0] GEN0 = 30'h3b6a57b2;
	localparam logic [29:0] GEN1 = 30'h26508e6d;
	localparam logic [29:0] GEN2 = 30'h1ea119fa;
	localparam logic [29:0] GEN3 = 30'h3d4233dd;
	localparam logic [29:0] GEN4 = 30'h2a1462b3;

	localparam logic [29:0] CHK_INIT      = 30'h00000001;
	localparam logic [29:0] BECH32_CONST  = 30'h00000001;
	localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;

	localparam logic [6:0] CHAR_B   = 7'h62;
	localparam logic [6:0] CHAR_C   = 7'h63;
	localparam logic [6:0] CHAR_ONE = 7'h31;

	// hrp "bc" expansion folded in ahead of the version symbol
	localparam logic [4:0] HRP_X0 = 5'd3;
	localparam logic [4:0] HRP_X1 = 5'd3;
	localparam logic [4:0] HRP_X2 = 5'd0;
	localparam logic [4:0] HRP_X3 = 5'd2;
	localparam logic [4:0] HRP_X4 = 5'd3;

	typedef struct packed {
		logic       first;
		logic [4:0] ver;
		logic [4:0] sym0;
		logic [4:0] sym1;
		logic       two;
		logic       pad_en;
		logic [4:0] pad_sym;
		logic       last;
	} job_t;

	function automatic logic [29:0] fold(input logic [29:0] chk, input logic [4:0] sym);
		logic [4:0]  top;
		logic [29:0] c;
		top = chk[29:25];
		c = {chk[24:0], sym};
		if (top[0]) c = c ^ GEN0;
		if (top[1]) c = c ^ GEN1;
		if (top[2]) c = c ^ GEN2;
		if (top[3]) c = c ^ GEN3;
		if (top[4]) c = c ^ GEN4;
		return c;
	endfunction

	localparam logic [29:0] PREFIX_CHK =
		fold(fold(fold(fold(fold(CHK_INIT, HRP_X0), HRP_X1), HRP_X2), HRP_X3), HRP_X4);

	function automatic logic [6:0] alpha(input logic [4:0] sym);
		logic [6:0] ch;
		case (sym)
			5'd0: ch = 7'h71;  5'd1: ch = 7'h70;  5'd2: ch = 7'h7a;  5'd3: ch = 7'h72;
			5'd4: ch = 7'h79;  5'd5: ch = 7'h39;  5'd6: ch = 7'h78;  5'd7: ch = 7'h38;
			5'd8: ch = 7'h67;  5'd9: ch = 7'h66;  5'd10: ch = 7'h32; 5'd11: ch = 7'h74;
			5'd12: ch = 7'h76; 5'd13: ch = 7'h64; 5'd14: ch = 7'h77; 5'd15: ch = 7'h30;
			5'd16: ch = 7'h73; 5'd17: ch = 7'h33; 5'd18: ch = 7'h6a; 5'd19: ch = 7'h6e;
			5'd20: ch = 7'h35; 5'd21: ch = 7'h34; 5'd22: ch = 7'h6b; 5'd23: ch = 7'h68;
			5'd24: ch = 7'h63; 5'd25: ch = 7'h65; 5'd26: ch = 7'h36; 5'd27: ch = 7'h6d;
			5'd28: ch = 7'h75; 5'd29: ch = 7'h61; 5'd30: ch = 7'h37;
			default: ch = 7'h6c;
		endcase
		return ch;
	endfunction

endpackage

### hdl/bae_front.sv
// Front end: regroups program bytes into 5-bit symbols and builds queue jobs.
// Depends on bae_pkg.
module bae_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        program_byte,
	input  logic [4:0]        witness_version,
	input  logic              first_byte,
	input  logic              last_byte,
	output bae_pkg::job_t     job
);

	logic [3:0]  left_q;
	logic [2:0]  lcnt_q;
	logic [3:0]  eff_left;
	logic [2:0]  eff_cnt;
	logic [11:0] acc;
	logic [3:0]  nl;
	logic [2:0]  nc;

	always_comb begin
		eff_left = first_byte ? 4'd0 : left_q;
		eff_cnt  = first_byte ? 3'd0 : lcnt_q;
		acc = {eff_left, program_byte};
		job.first = first_byte;
		job.ver   = witness_version;
		job.last  = last_byte;
		job.sym1  = 5'd0;
		job.two   = 1'b0;
		case (eff_cnt)
			3'd0: begin
				job.sym0 = acc[7:3];
				nl = {1'b0, acc[2:0]};
				nc = 3'd3;
			end
			3'd1: begin
				job.sym0 = acc[8:4];
				nl = acc[3:0];
				nc = 3'd4;
			end
			3'd2: begin
				job.sym0 = acc[9:5];
				job.sym1 = acc[4:0];
				job.two = 1'b1;
				nl = 4'd0;
				nc = 3'd0;
			end
			3'd3: begin
				job.sym0 = acc[10:6];
				job.sym1 = acc[5:1];
				job.two = 1'b1;
				nl = {3'b0, acc[0]};
				nc = 3'd1;
			end
			default: begin
				job.sym0 = acc[11:7];
				job.sym1 = acc[6:2];
				job.two = 1'b1;
				nl = {2'b0, acc[1:0]};
				nc = 3'd2;
			end
		endcase
		case (nc)
			3'd1: job.pad_sym = {nl[0], 4'b0};
			3'd2: job.pad_sym = {nl[1:0], 3'b0};
			3'd3: job.pad_sym = {nl[2:0], 2'b0};
			3'd4: job.pad_sym = {nl[3:0], 1'b0};
			default: job.pad_sym = 5'd0;
		endcase
		job.pad_en = last_byte && (nc != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 4'd0;
			lcnt_q <= 3'd0;
		end else if (push) begin
			if (last_byte) begin
				left_q <= 4'd0;
				lcnt_q <= 3'd0;
			end else begin
				left_q <= nl;
				lcnt_q <= nc;
			end
		end
	end

endmodule

### hdl/bae_queue.sv
// Short job queue between the front and back ends.
// Depends on bae_pkg for the job type.
module bae_queue #(
	parameter int unsigned DEPTH = bae_pkg::QDEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bae_pkg::job_t              wr_job,
	input  logic                       pop,
	output bae_pkg::job_t              head,
	output logic                       full,
	output logic                       nonempty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bae_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head     = mem_q[rd_ptr_q];
	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### hdl/bae_back.sv
// Back end: steps through each job, folds the checksum, drives the output word.
// Depends on bae_pkg.
module bae_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bae_pkg::job_t     head,
	input  logic              job_valid,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	localparam logic [3:0] ST_B    = 4'd0;
	localparam logic [3:0] ST_C    = 4'd1;
	localparam logic [3:0] ST_ONE  = 4'd2;
	localparam logic [3:0] ST_VER  = 4'd3;
	localparam logic [3:0] ST_SYM0 = 4'd4;
	localparam logic [3:0] ST_SYM1 = 4'd5;
	localparam logic [3:0] ST_PAD  = 4'd6;
	localparam logic [3:0] ST_ZERO = 4'd7;
	localparam logic [3:0] ST_CHK  = 4'd8;

	logic        busy_q;
	logic [3:0]  step_q;
	logic [2:0]  cnt_q;
	logic [29:0] chk_q;
	logic        b32m_q;
	logic        ovalid_q;
	logic [6:0]  ochar_q;
	logic        olast_q;

	logic [3:0]  cur_step;
	logic [2:0]  cur_cnt;
	logic [3:0]  nxt_step;
	logic [2:0]  nxt_cnt;
	logic [3:0]  after_syms;
	logic        fin;
	logic        emits;
	logic        out_free;
	logic        fire;
	logic        cnt_end;
	logic [4:0]  fsym;
	logic [29:0] folded;
	logic [6:0]  ch;

	always_comb begin
		cur_step   = busy_q ? step_q : (head.first ? ST_B : ST_SYM0);
		cur_cnt    = busy_q ? cnt_q : 3'd0;
		cnt_end    = (cur_cnt == 3'd5);
		emits      = (cur_step != ST_ZERO);
		out_free   = !ovalid_q || m_tready;
		fire       = job_valid && (!emits || out_free);
		after_syms = head.pad_en ? ST_PAD : ST_ZERO;
		nxt_step   = cur_step;
		nxt_cnt    = 3'd0;
		fin        = 1'b0;
		fsym       = 5'd0;
		ch         = bae_pkg::alpha(chk_q[29:25]);
		case (cur_step)
			ST_B: begin
				nxt_step = ST_C;
				ch = bae_pkg::CHAR_B;
			end
			ST_C: begin
				nxt_step = ST_ONE;
				ch = bae_pkg::CHAR_C;
			end
			ST_ONE: begin
				nxt_step = ST_VER;
				ch = bae_pkg::CHAR_ONE;
			end
			ST_VER: begin
				nxt_step = ST_SYM0;
				fsym = head.ver;
			end
			ST_SYM0: begin
				fsym = head.sym0;
				if (head.two) begin
					nxt_step = ST_SYM1;
				end else begin
					nxt_step = after_syms;
					fin = !head.last;
				end
			end
			ST_SYM1: begin
				fsym = head.sym1;
				nxt_step = after_syms;
				fin = !head.last;
			end
			ST_PAD: begin
				fsym = head.pad_sym;
				nxt_step = ST_ZERO;
			end
			ST_ZERO: begin
				nxt_step = cnt_end ? ST_CHK : ST_ZERO;
				nxt_cnt = cnt_end ? 3'd0 : cur_cnt + 3'd1;
			end
			default: begin
				nxt_cnt = cur_cnt + 3'd1;
				fin = cnt_end;
			end
		endcase
		if (cur_step inside {ST_VER, ST_SYM0, ST_SYM1, ST_PAD}) begin
			ch = bae_pkg::alpha(fsym);
		end
		folded = bae_pkg::fold(chk_q, fsym);
		pop = fire && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_B;
			cnt_q  <= 3'd0;
			chk_q  <= bae_pkg::CHK_INIT;
			b32m_q <= 1'b0;
		end else if (fire) begin
			busy_q <= !fin;
			step_q <= nxt_step;
			cnt_q  <= nxt_cnt;
			case (cur_step)
				ST_B, ST_C: begin
				end
				ST_ONE: begin
					chk_q  <= bae_pkg::PREFIX_CHK;
					b32m_q <= (head.ver != 5'd0);
				end
				ST_ZERO: begin
					if (cnt_end) begin
						chk_q <= folded ^ (b32m_q ? bae_pkg::BECH32M_CONST
							: bae_pkg::BECH32_CONST);
					end else begin
						chk_q <= folded;
					end
				end
				ST_CHK: begin
					if (cnt_end) begin
						chk_q  <= bae_pkg::CHK_INIT;
						b32m_q <= 1'b0;
					end else begin
						chk_q <= {chk_q[24:0], 5'd0};
					end
				end
				default: begin
					chk_q <= folded;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (fire && emits) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emits) begin
			ochar_q <= ch;
			olast_q <= (cur_step == ST_CHK) && cnt_end;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, ochar_q};
	assign m_tlast  = olast_q;

endmodule

### hdl/bech32_address_encoder_top.sv
// Top level of the bech32 segwit address encoder ("bc" prefix).
// Depends on bae_pkg, bae_front, bae_queue and bae_back.
//
// channel  dir  tdata                              tuser       tlast
// s_*      in   [7:0] program_byte, [12:8] version [0] first   last_byte
// m_*      out  [6:0] address_char                 -           last_char
//
// One word in per cycle while the job queue has room; the front end is combinational
// and hands each byte straight to the queue.
// The back end emits one character per cycle over the single output register while
// a job is queued and the output is not stalled: 1 or 2 per byte, 4 more on a first
// byte, a pad if bits are left plus six checksum characters on a last byte; the six
// zero-symbol folds there emit nothing.
// arst_n clears pointers, sequencer and checksum at once; a stalled output holds
// the back end while the front keeps filling the queue.
module bech32_address_encoder_top #(
	parameter int unsigned QDEPTH = bae_pkg::QDEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] program_byte, [12:8] witness_version, [15:13] zero
	input  logic        s_tuser,  // [0] first_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] address_char, [7] zero
	output logic        m_tlast
);

	localparam int unsigned CW = $clog2(QDEPTH + 1);

	bae_pkg::job_t  new_job;
	bae_pkg::job_t  head;
	logic           push;
	logic           pop;
	logic           full;
	logic           nonempty;
	logic [CW-1:0]  count;

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	bae_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.program_byte    (s_tdata[7:0]),
		.witness_version (s_tdata[12:8]),
		.first_byte      (s_tuser),
		.last_byte       (s_tlast),
		.job             (new_job)
	);

	bae_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (new_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.nonempty (nonempty),
		.count    (count)
	);

	bae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.job_valid (nonempty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("job popped from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count == $past(count) + CW'(1)))
		else $error("queue count did not advance on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count == $past(count) - CW'(1)))
		else $error("queue count did not drop on pop");

endmodule

### dv/bech32_address_encoder_top_tb.sv
// Self-checking bench for bech32_address_encoder_top: witness programs in, address text out.
// Predicts every character from its own checksum model and compares in order.
// Needs only the RTL under hdl; no files, no arguments.
`timescale 1ns / 100ps

module bech32_address_encoder_top_tb;

	localparam int ITEMS_TOTAL = 310;
	localparam int SETTLE_CYCLES = 40;

	localparam bit [0:4][29:0] BCH_GEN = {
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};
	localparam bit [0:31][7:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam bit [0:4][4:0] PREFIX_SYMS = {5'd3, 5'd3, 5'd0, 5'd2, 5'd3};
	localparam logic [29:0] CONST_BECH32 = 30'h00000001;
	localparam logic [29:0] CONST_BECH32M = 30'h2bc830a3;

	typedef struct packed {
		logic       hold_drain;
		logic       first;
		logic       last;
		logic [4:0] ver;
		logic [7:0] pbyte;
	} prog_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	prog_word_t pending_words[$];
	logic [7:0] address_chars[$];   // [7] last_char, [6:0] address_char

	logic [29:0] chk_state = 30'h1;
	logic [3:0]  spare_bits = '0;
	logic [2:0]  spare_count = '0;
	logic        bech32m_sel = 1'b0;

	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	bit   in_calm = 1'b0;
	bit   out_calm = 1'b0;
	int   tx_wait = 0;
	int   rx_wait = 0;
	int   rx_next;
	int   words_taken = 0;
	int   chars_checked = 0;
	int   programs_queued = 0;
	int   errors = 0;

	bech32_address_encoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap(bit calm);
		return calm ? 0 : int'($urandom_range(0, 14));
	endfunction

	function automatic void advance_chk(logic [4:0] sym);
		logic [4:0]  top;
		logic [29:0] nxt;
		top = chk_state[29:25];
		nxt = {chk_state[24:0], sym};
		for (int g = 0; g < 5; g++)
			if (top[g]) nxt = nxt ^ BCH_GEN[g];
		chk_state = nxt;
	endfunction

	function automatic void emit_sym(logic [4:0] sym);
		advance_chk(sym);
		address_chars.insert(address_chars.size(), {1'b0, ALPHABET[sym][6:0]});
	endfunction

	function automatic void encode_word(prog_word_t w);
		logic [11:0] acc;
		logic [11:0] sh;
		logic [4:0]  pad;
		logic [29:0] tail;
		int          nbits;
		if (w.first) begin
			chk_state = 30'h1;
			spare_bits = '0;
			spare_count = '0;
			bech32m_sel = (w.ver != 5'd0);
			address_chars.insert(address_chars.size(), {1'b0, 7'h62});
			address_chars.insert(address_chars.size(), {1'b0, 7'h63});
			address_chars.insert(address_chars.size(), {1'b0, 7'h31});
			for (int i = 0; i < 5; i++)
				advance_chk(PREFIX_SYMS[i]);
			emit_sym(w.ver);
		end
		nbits = (spare_count > 3'd4) ? 4 : int'(spare_count);
		nbits += 8;
		acc = {spare_bits, w.pbyte};
		while (nbits >= 5) begin
			nbits -= 5;
			sh = acc >> nbits;
			emit_sym(sh[4:0]);
		end
		spare_bits = acc[3:0] & ((4'd1 << nbits) - 4'd1);
		spare_count = nbits[2:0];
		if (w.last) begin
			if (spare_count != 3'd0) begin
				pad = {1'b0, spare_bits} << (5 - spare_count);
				emit_sym(pad);
			end
			for (int i = 0; i < 6; i++)
				advance_chk(5'd0);
			tail = chk_state ^ (bech32m_sel ? CONST_BECH32M : CONST_BECH32);
			for (int i = 0; i < 6; i++)
				address_chars.insert(address_chars.size(),
					{i == 5, ALPHABET[tail[5 * (5 - i) +: 5]][6:0]});
			chk_state = 30'h1;
			spare_bits = '0;
			spare_count = '0;
			bech32m_sel = 1'b0;
		end
	endfunction

	// feed words from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (tx_wait > 0) begin
				s_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (pending_words.size() != 0 &&
					!(pending_words[0].hold_drain && address_chars.size() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, pending_words[0].ver, pending_words[0].pbyte};
				s_tuser <= pending_words[0].first;
				s_tlast <= pending_words[0].last;
				pending_words.delete(0);
				tx_wait <= draw_gap(in_calm);
				if ($urandom_range(0, 19) == 0)
					in_calm <= ~in_calm;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// stall the output side
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_next = rx_wait;
			if (out_taken) begin
				rx_next = draw_gap(out_calm);
				if ($urandom_range(0, 19) == 0)
					out_calm <= ~out_calm;
			end
			if (rx_next > 0) begin
				m_tready <= 1'b0;
				rx_wait <= rx_next - 1;
			end else begin
				m_tready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	// predict on accepted input, check accepted output
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			out_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				encode_word('{hold_drain: 1'b0, first: s_tuser, last: s_tlast,
					ver: s_tdata[12:8], pbyte: s_tdata[7:0]});
				words_taken <= words_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				chars_checked <= chars_checked + 1;
				if (address_chars.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual char %h last %b",
						$time, m_tdata[6:0], m_tlast);
					errors = errors + 1;
				end else begin
					if (m_tdata[6:0] !== address_chars[0][6:0]) begin
						$display("%0t: address_char expected %h actual %h",
							$time, address_chars[0][6:0], m_tdata[6:0]);
						errors = errors + 1;
					end
					if (m_tlast !== address_chars[0][7]) begin
						$display("%0t: last_char expected %b actual %b",
							$time, address_chars[0][7], m_tlast);
						errors = errors + 1;
					end
					address_chars.delete(0);
				end
			end
		end
	end

	task automatic queue_word(input logic [7:0] pbyte, input logic [4:0] ver,
			input logic first, input logic last, input logic drain);
		prog_word_t w;
		w = '{hold_drain: drain, first: first, last: last, ver: ver, pbyte: pbyte};
		pending_words.insert(pending_words.size(), w);
		if (first)
			programs_queued++;
	endtask

	initial begin
		int total_words;
		int len;
		int pick;
		int noise;
		logic [4:0] ver;
		logic drain;

		// byte with no program open, then close it
		queue_word(8'h00, 5'd0, 1'b0, 1'b0, 1'b0);
		queue_word(8'hff, 5'd31, 1'b0, 1'b1, 1'b0);
		// single-byte programs with both marks
		queue_word(8'h00, 5'd0, 1'b1, 1'b1, 1'b0);
		queue_word(8'hff, 5'd1, 1'b1, 1'b1, 1'b1);
		queue_word(8'h80, 5'd31, 1'b1, 1'b1, 1'b0);
		// four-byte Bech32 program
		queue_word(8'h00, 5'd0, 1'b1, 1'b0, 1'b0);
		queue_word(8'hff, 5'd0, 1'b0, 1'b0, 1'b0);
		queue_word(8'ha5, 5'd0, 1'b0, 1'b0, 1'b0);
		queue_word(8'h5a, 5'd0, 1'b0, 1'b1, 1'b0);
		// restart mid-program
		queue_word(8'h12, 5'd2, 1'b1, 1'b0, 1'b1);
		queue_word(8'h34, 5'd0, 1'b0, 1'b0, 1'b0);
		queue_word(8'h56, 5'd0, 1'b1, 1'b0, 1'b0);
		queue_word(8'hff, 5'd0, 1'b0, 1'b1, 1'b0);
		// continue after a closed program
		queue_word(8'h01, 5'd0, 1'b0, 1'b0, 1'b0);
		queue_word(8'h02, 5'd0, 1'b0, 1'b1, 1'b0);
		// version 16
		queue_word(8'h7f, 5'd16, 1'b1, 1'b0, 1'b0);
		queue_word(8'hfe, 5'd15, 1'b0, 1'b1, 1'b0);

		while (pending_words.size() < ITEMS_TOTAL) begin
			if ($urandom_range(0, 99) < 85) begin
				pick = $urandom_range(0, 9);
				len = (pick < 5) ? 20 : (pick < 7) ? 32 : int'($urandom_range(1, 12));
				pick = $urandom_range(0, 9);
				ver = (pick < 4) ? 5'd0 : (pick < 7) ? 5'd1 : 5'($urandom_range(0, 31));
				drain = ($urandom_range(0, 9) == 0);
				for (int i = 0; i < len; i++)
					queue_word(8'($urandom_range(0, 255)),
						(i == 0) ? ver : 5'($urandom_range(0, 31)),
						i == 0, i == len - 1, drain && i == 0);
			end else begin
				noise = $urandom_range(1, 3);
				for (int i = 0; i < noise; i++)
					queue_word(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
			end
		end
		total_words = pending_words.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(words_taken == total_words && address_chars.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d words over %0d marked programs plus stray bytes",
			words_taken, programs_queued);
		$display("%0d address characters compared, %0d mismatches", chars_checked, errors);
		if (errors == 0 && address_chars.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

### sim.f
hdl/bae_pkg.sv
hdl/bae_front.sv
hdl/bae_queue.sv
hdl/bae_back.sv
hdl/bech32_address_encoder_top.sv
dv/bech32_address_encoder_top_tb.sv
